// File: rtl/tlb_pkg.sv
// Shared types and constants for the translation buffer.
// Used by the top level. No dependencies.
package tlb_pkg;

	localparam int unsigned PAGE_W = 20;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned OP_W   = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ACCESS = 2'd0,
		OP_PROBE  = 2'd1,
		OP_FLUSH  = 2'd2
	} tlb_op_t;

	// One stored entry, page in the low bits.
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [PAGE_W-1:0] frame;
		logic [PAGE_W-1:0] page;
	} xlat_line_t;

	localparam int unsigned ENTRY_W = $bits(xlat_line_t);

endpackage

// File: rtl/tlb_lookup_with_lru_fifo_replacement_top.sv
// Fully associative translation buffer with LRU or FIFO replacement.
// Depends on tlb_pkg and tlb_ram.
//
// Usage:
//   Input words come in on s_tvalid/s_tready/s_tdata/s_tuser. tuser is the
//   operation (access, probe, flush); tdata carries page and frame.
//   Each word gives exactly one result word on m_tvalid/m_tready.
//   The replacement policy is written through cfg_valid/cfg_data; the user
//   must write it only while the block is idle, which the block itself does
//   not enforce. cfg_ready is always high. An access or probe walks the
//   filled entries once through the entry RAM: one read per cycle, each read
//   compared from its registered read data and, for an access, its counter written back in
//   the same cycle. The next word is taken the cycle after the result is
//   loaded. Flush and the unused code skip the walk; the walk itself is
//   sequential over the single entry RAM.
//   At reset the buffer is empty, the policy is LRU and no result is held.
//   If the receiver stalls, the result stays in the output register and
//   the block still accepts and works the next word, then waits to deliver.
module tlb_lookup_with_lru_fifo_replacement_top #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,    // replace_policy
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // [19:0] page_number, [39:20] frame_number
	input  logic [1:0]  s_tuser,     // operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [19:0] frame_out, [23:20] slot, [24] evicted
	output logic        m_tuser      // hit
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FW = $clog2(ENTRIES + 1);
	localparam logic [FW-1:0] FULL = FW'(ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic                           policy_q;
	logic [FW-1:0]                  fill_q;
	logic [tlb_pkg::OP_W-1:0]       op_q;
	logic [tlb_pkg::PAGE_W-1:0]     page_q;
	logic [tlb_pkg::PAGE_W-1:0]     frame_q;

	// walker
	logic [FW-1:0]                  rd_idx_q;
	logic                           proc_vld_q;
	logic [IW-1:0]                  proc_idx_q;
	logic                           hit_q;
	logic [IW-1:0]                  hit_slot_q;
	logic [tlb_pkg::PAGE_W-1:0]     hit_frame_q;
	logic [tlb_pkg::CNT_W-1:0]      best_q;
	logic [IW-1:0]                  best_idx_q;

	// output register
	logic                           out_vld_q;
	logic                           out_hit_q;
	logic [tlb_pkg::PAGE_W-1:0]     out_frame_q;
	logic [tlb_pkg::SLOT_W-1:0]     out_slot_q;
	logic                           out_ev_q;

	// RAM
	logic                           ram_we;
	logic [IW-1:0]                  ram_waddr;
	tlb_pkg::xlat_line_t            ram_wentry;
	logic [tlb_pkg::ENTRY_W-1:0]    ram_rdata;
	tlb_pkg::xlat_line_t            rd_entry;

	logic                           rd_more;
	logic                           match;
	logic                           first_hit;
	logic [tlb_pkg::CNT_W-1:0]      raised;
	logic [tlb_pkg::CNT_W-1:0]      new_cnt;
	logic                           out_free;
	logic                           load_out;
	logic                           is_access;
	logic                           need_install;
	logic [IW-1:0]                  victim;

	logic                           res_hit;
	logic [tlb_pkg::PAGE_W-1:0]     res_frame;
	logic [IW-1:0]                  res_idx;
	logic                           res_ev;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_vld_q;
	assign m_tuser   = out_hit_q;
	assign m_tdata   = {7'd0, out_ev_q, out_slot_q, out_frame_q};

	assign is_access = (op_q == tlb_pkg::OP_ACCESS);
	assign rd_more   = (state_q == ST_SCAN) && (rd_idx_q < fill_q);
	assign out_free  = !out_vld_q || m_tready;
	assign load_out  = (state_q == ST_DONE) && out_free;

	assign rd_entry  = tlb_pkg::xlat_line_t'(ram_rdata);
	assign match     = (rd_entry.page == page_q);
	assign first_hit = proc_vld_q && match && !hit_q;
	assign raised    = (rd_entry.cnt == tlb_pkg::CNT_MAX) ? rd_entry.cnt
	                                                       : rd_entry.cnt + 1'b1;
	// LRU clears the counter of the entry that hit; everything else ages
	assign new_cnt   = (!policy_q && first_hit) ? '0 : raised;

	assign need_install = load_out && is_access && !hit_q;
	assign victim       = (fill_q < FULL) ? fill_q[IW-1:0] : best_idx_q;

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = proc_idx_q;
		ram_wentry = '{cnt: new_cnt, frame: rd_entry.frame, page: rd_entry.page};
		if (state_q == ST_SCAN && proc_vld_q && is_access) begin
			ram_we = 1'b1;
		end else if (need_install) begin
			ram_we     = 1'b1;
			ram_waddr  = victim;
			ram_wentry = '{cnt: '0, frame: frame_q, page: page_q};
		end
	end

	always_comb begin
		res_hit   = 1'b0;
		res_frame = '0;
		res_idx   = '0;
		res_ev    = 1'b0;
		case (op_q)
			tlb_pkg::OP_ACCESS: begin
				if (hit_q) begin
					res_hit   = 1'b1;
					res_frame = hit_frame_q;
					res_idx   = hit_slot_q;
				end else begin
					res_frame = frame_q;
					res_idx   = victim;
					res_ev    = (fill_q >= FULL);
				end
			end
			tlb_pkg::OP_PROBE: begin
				if (hit_q) begin
					res_hit   = 1'b1;
					res_frame = hit_frame_q;
					res_idx   = hit_slot_q;
				end
			end
			default: begin
			end
		endcase
	end

	tlb_ram #(
		.WIDTH (tlb_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			policy_q   <= 1'b0;
			fill_q     <= '0;
			out_vld_q  <= 1'b0;
			proc_vld_q <= 1'b0;
			hit_q      <= 1'b0;
			rd_idx_q   <= '0;
			op_q       <= '0;
		end else begin
			if (cfg_valid) begin
				policy_q <= cfg_data;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= s_tuser;
						page_q     <= s_tdata[19:0];
						frame_q    <= s_tdata[39:20];
						hit_q      <= 1'b0;
						best_q     <= '0;
						best_idx_q <= '0;
						rd_idx_q   <= '0;
						proc_vld_q <= 1'b0;
						if (s_tuser == tlb_pkg::OP_ACCESS || s_tuser == tlb_pkg::OP_PROBE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					proc_vld_q <= rd_more;
					proc_idx_q <= rd_idx_q[IW-1:0];
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (first_hit) begin
						hit_q       <= 1'b1;
						hit_slot_q  <= proc_idx_q;
						hit_frame_q <= rd_entry.frame;
					end
					// victim search skips the hit entry; strict > keeps lowest index
					if (proc_vld_q && !first_hit && raised > best_q) begin
						best_q     <= raised;
						best_idx_q <= proc_idx_q;
					end
					if (!rd_more && !proc_vld_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_hit_q   <= res_hit;
						out_frame_q <= res_frame;
						out_slot_q  <= tlb_pkg::SLOT_W'(res_idx);
						out_ev_q    <= res_ev;
						if (op_q == tlb_pkg::OP_FLUSH) begin
							fill_q <= '0;
						end else if (need_install && fill_q < FULL) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill count never runs past the buffer size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count exceeds entries");

	// write-back during the walk never lands on the address being read
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && rd_more) |-> (ram_waddr != rd_idx_q[IW-1:0]))
		else $error("RAM write collides with walker read");

	// an eviction only happens on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tdata[24]))
		else $error("eviction reported on a hit");

	// installs only come from an access that missed the walk
	a_install_src: assert property (@(posedge clk) disable iff (!arst_n)
		need_install |-> (is_access && !hit_q && !proc_vld_q))
		else $error("install outside an access miss");

endmodule

// File: rtl/tlb_ram.sv
// Generic two-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tlb_ram #(
	parameter int unsigned WIDTH = 56,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
